// ===== rtl/rgb_to_display_pixel_converter_unit_assert.svh =====
// assertion macros for the pixel converter
`ifndef RGB_TO_DISPLAY_PIXEL_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_DISPLAY_PIXEL_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define RDPC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdpc: same-cycle check failed");

`define RDPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdpc: next-cycle check failed");

`else

`define RDPC_ASSERT_IMPLY(name, clk, rst, ante, cons)

`define RDPC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/rdpc_pkg.sv =====
`default_nettype none

package rdpc_pkg;

   localparam int CHAN_BITS         = 8;
   localparam int MASK_BITS         = 32;
   localparam int PIX_FIELD_BITS    = 32;
   localparam int LEVEL_BITS        = 3;
   localparam int QUANT_PROD_BITS   = CHAN_BITS + LEVEL_BITS;
   localparam int ROW_BITS          = 6;
   localparam int CUBE_IDX_BITS     = 9;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CUBE_ENTRIES_DEF  = 256;
   localparam int PIXEL_BITS_DEF    = 32;
   // largest cube with six levels per channel
   localparam int CUBE_FULL_ENTRIES = 216;

   localparam logic [LEVEL_BITS-1:0] RED_LEVELS_RST   = 3'd6;
   localparam logic [LEVEL_BITS-1:0] GREEN_LEVELS_RST = 3'd6;
   localparam logic [LEVEL_BITS-1:0] BLUE_LEVELS_RST  = 3'd5;
   localparam logic [LEVEL_BITS-1:0] MAX_LEVELS       = 3'd6;

   typedef enum logic {
      CMD_CONVERT = 1'b0,
      CMD_LOAD    = 1'b1
   } cmd_type;

   typedef enum logic {
      MODE_TRUE_COLOR = 1'b0,
      MODE_CUBE       = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COLOR_MODE   = 3'd0,
      CSR_RED_MASK     = 3'd1,
      CSR_GREEN_MASK   = 3'd2,
      CSR_BLUE_MASK    = 3'd3,
      CSR_RED_LEVELS   = 3'd4,
      CSR_GREEN_LEVELS = 3'd5,
      CSR_BLUE_LEVELS  = 3'd6
   } csr_addr_type;

   // which channel bit lands on one pixel bit
   typedef struct packed {
      logic       en;
      logic [2:0] sel;
   } lane_sel_type;

   typedef lane_sel_type [MASK_BITS-1:0] mask_map_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] green;
      logic [LEVEL_BITS-1:0] blue;
   } cube_levels_type;

   typedef struct packed {
      logic                 en;
      csr_addr_type         index;
      logic [MASK_BITS-1:0] data;
   } csr_wr_type;

   typedef struct packed {
      logic s1;
      logic s2;
   } pipe_en_type;

   // rank of each set mask bit counted from the top, first eight only
   function automatic mask_map_type build_lane_map(input logic [MASK_BITS-1:0] mask);
      mask_map_type         m;
      logic [MASK_BITS-1:0] above;
      logic [5:0]           rank;
      for (int b = 0; b < MASK_BITS; b++) begin
         above    = mask >> (b + 1);
         rank     = 6'($countones(above));
         m[b].en  = mask[b] && (rank < 6'd8);
         m[b].sel = 3'd7 - rank[2:0];
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rdpc_mask_pack.sv =====
`default_nettype none

module rdpc_mask_pack
   import rdpc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire csr_wr_type                csr_wr,
   input  wire logic [CHAN_BITS-1:0]      red_in,
   input  wire logic [CHAN_BITS-1:0]      green_in,
   input  wire logic [CHAN_BITS-1:0]      blue_in,
   output logic      [PIX_FIELD_BITS-1:0] packed_pixel
);

   mask_map_type red_map_ff, green_map_ff, blue_map_ff;
   mask_map_type red_map_in, green_map_in, blue_map_in;
   mask_map_type new_map;

   // maps are rebuilt once per mask write, the item path only selects
   always_comb begin
      new_map      = build_lane_map(csr_wr.data);
      red_map_in   = red_map_ff;
      green_map_in = green_map_ff;
      blue_map_in  = blue_map_ff;
      if (csr_wr.en) begin
         case (csr_wr.index)
            CSR_RED_MASK:   red_map_in   = new_map;
            CSR_GREEN_MASK: green_map_in = new_map;
            CSR_BLUE_MASK:  blue_map_in  = new_map;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_map_ff   <= '0;
         green_map_ff <= '0;
         blue_map_ff  <= '0;
      end else begin
         red_map_ff   <= red_map_in;
         green_map_ff <= green_map_in;
         blue_map_ff  <= blue_map_in;
      end
   end

   always_comb begin
      for (int b = 0; b < PIX_FIELD_BITS; b++) begin
         packed_pixel[b] = (red_map_ff[b].en   && red_in[red_map_ff[b].sel])
                        || (green_map_ff[b].en && green_in[green_map_ff[b].sel])
                        || (blue_map_ff[b].en  && blue_in[blue_map_ff[b].sel]);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rdpc_cube_index.sv =====
`default_nettype none

module rdpc_cube_index
   import rdpc_pkg::*;
(
   input  wire logic                     clock,
   input  wire pipe_en_type              en,
   input  wire cube_levels_type          levels,
   input  wire logic [CHAN_BITS-1:0]     red_in,
   input  wire logic [CHAN_BITS-1:0]     green_in,
   input  wire logic [CHAN_BITS-1:0]     blue_in,
   output logic      [CUBE_IDX_BITS-1:0] cube_idx
);

   logic [QUANT_PROD_BITS-1:0] red_prod, green_prod, blue_prod;
   logic [LEVEL_BITS-1:0]      rq_ff, gq_ff, bq_ff;
   logic [LEVEL_BITS-1:0]      rq_in, gq_in, bq_in;
   logic [ROW_BITS-1:0]        row_ff, row_in;
   logic [LEVEL_BITS-1:0]      bq2_ff, bq2_in;

   // stage 1: quantize each channel as (value * levels) >> 8
   always_comb begin
      red_prod   = QUANT_PROD_BITS'(red_in)   * QUANT_PROD_BITS'(levels.red);
      green_prod = QUANT_PROD_BITS'(green_in) * QUANT_PROD_BITS'(levels.green);
      blue_prod  = QUANT_PROD_BITS'(blue_in)  * QUANT_PROD_BITS'(levels.blue);
      rq_in      = en.s1 ? red_prod[QUANT_PROD_BITS-1:CHAN_BITS]   : rq_ff;
      gq_in      = en.s1 ? green_prod[QUANT_PROD_BITS-1:CHAN_BITS] : gq_ff;
      bq_in      = en.s1 ? blue_prod[QUANT_PROD_BITS-1:CHAN_BITS]  : bq_ff;
   end

   // stage 2: rq * greens + gq
   always_comb begin
      row_in = en.s2 ? (ROW_BITS'(rq_ff) * ROW_BITS'(levels.green) + ROW_BITS'(gq_ff))
                     : row_ff;
      bq2_in = en.s2 ? bq_ff : bq2_ff;
   end

   always_ff @(posedge clock) begin
      rq_ff  <= rq_in;
      gq_ff  <= gq_in;
      bq_ff  <= bq_in;
      row_ff <= row_in;
      bq2_ff <= bq2_in;
   end

   // final multiply-add feeds the table address
   assign cube_idx = CUBE_IDX_BITS'(row_ff) * CUBE_IDX_BITS'(levels.blue)
                   + CUBE_IDX_BITS'(bq2_ff);

endmodule

`default_nettype wire

// ===== rtl/rdpc_cube_ram.sv =====
`default_nettype none

module rdpc_cube_ram
   import rdpc_pkg::*;
#(
   parameter int DEPTH  = CUBE_ENTRIES_DEF,
   parameter int DATA_W = PIX_FIELD_BITS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rgb_to_display_pixel_converter_unit.sv =====
// latency: a convert item passes through stage registers s1, s2 and s3 and shows on rsp from s3
// throughput: one item per cycle unless rsp stalls, set by the three-stage datapath and one table read port
// empty pipeline slots close up, so req stalls only when all three stages are full
// reset: synchronous, clears stage valids and config registers to their defaults
// the pixel table is not cleared by reset
`default_nettype none

`include "rgb_to_display_pixel_converter_unit_assert.svh"

module rgb_to_display_pixel_converter_unit
   import rdpc_pkg::*;
#(
   parameter int CUBE_ENTRIES = CUBE_ENTRIES_DEF,
   parameter int PIXEL_BITS   = PIXEL_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_cmd,
   input  wire logic [CHAN_BITS-1:0]      req_red_in,
   input  wire logic [CHAN_BITS-1:0]      req_green_in,
   input  wire logic [CHAN_BITS-1:0]      req_blue_in,
   input  wire logic [CHAN_BITS-1:0]      req_entry_index,
   input  wire logic [PIX_FIELD_BITS-1:0] req_entry_pixel,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic      [PIX_FIELD_BITS-1:0] rsp_pixel_out,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [MASK_BITS-1:0]      csr_wdata
);

   localparam int ADDR_W = $clog2(CUBE_ENTRIES);
   localparam int DATA_W = (PIXEL_BITS < PIX_FIELD_BITS) ? PIXEL_BITS : PIX_FIELD_BITS;
   localparam logic [PIX_FIELD_BITS-1:0] OUT_MASK = (PIXEL_BITS >= PIX_FIELD_BITS) ? '1 :
      PIX_FIELD_BITS'((64'(1) << PIXEL_BITS) - 64'(1));

   typedef struct packed {
      cmd_type                   cmd;
      logic [PIX_FIELD_BITS-1:0] tc;
      logic [CHAN_BITS-1:0]      entry_index;
      logic [PIX_FIELD_BITS-1:0] entry_pixel;
   } stage_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic [PIX_FIELD_BITS-1:0] tc;
      logic                      hit;
   } out_stage_type;

   // configuration
   csr_wr_type      csr_wr;
   mode_type        color_mode_ff, color_mode_in;
   cube_levels_type levels_ff, levels_in;

   // pipeline
   logic          v1_ff, v2_ff, v3_ff;
   logic          v1_in, v2_in, v3_in;
   stage_type     s1_ff, s2_ff, s1_in, s2_in;
   out_stage_type s3_ff, s3_in;
   logic          move1, move2, move3;
   pipe_en_type   pipe_en;

   logic [PIX_FIELD_BITS-1:0] packed_pixel;
   logic [CUBE_IDX_BITS-1:0]  cube_idx;
   logic                      cube_hit;
   logic                      cube_check_en;
   logic                      tbl_wr_en;
   logic [DATA_W-1:0]         tbl_rd_data;

   assign csr_ready     = 1'b1;
   assign csr_wr.en     = csr_valid && csr_ready;
   assign csr_wr.index  = csr_addr_type'(csr_index);
   assign csr_wr.data   = csr_wdata;

   always_comb begin
      color_mode_in = color_mode_ff;
      levels_in     = levels_ff;
      if (csr_wr.en) begin
         case (csr_wr.index)
            CSR_COLOR_MODE:   color_mode_in   = mode_type'(csr_wr.data[0]);
            CSR_RED_LEVELS:   levels_in.red   = csr_wr.data[LEVEL_BITS-1:0];
            CSR_GREEN_LEVELS: levels_in.green = csr_wr.data[LEVEL_BITS-1:0];
            CSR_BLUE_LEVELS:  levels_in.blue  = csr_wr.data[LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= MODE_TRUE_COLOR;
         levels_ff     <= '{red: RED_LEVELS_RST, green: GREEN_LEVELS_RST,
                            blue: BLUE_LEVELS_RST};
      end else begin
         color_mode_ff <= color_mode_in;
         levels_ff     <= levels_in;
      end
   end

   // a stage takes the next item when it is empty or its own item moves on
   always_comb begin
      move3       = !(rsp_valid && rsp_stall);
      move2       = !v2_ff || move3;
      move1       = !v1_ff || move2;
      req_stall   = !move1;
      pipe_en.s1  = move1;
      pipe_en.s2  = move2;
   end

   rdpc_mask_pack u_mask_pack (
      .clock        (clock),
      .reset        (reset),
      .csr_wr       (csr_wr),
      .red_in       (req_red_in),
      .green_in     (req_green_in),
      .blue_in      (req_blue_in),
      .packed_pixel (packed_pixel)
   );

   rdpc_cube_index u_cube_index (
      .clock    (clock),
      .en       (pipe_en),
      .levels   (levels_ff),
      .red_in   (req_red_in),
      .green_in (req_green_in),
      .blue_in  (req_blue_in),
      .cube_idx (cube_idx)
   );

   assign cube_hit  = 32'(cube_idx) < 32'(CUBE_ENTRIES);
   // loads write in the same slot where converts read, so order is kept
   assign tbl_wr_en = move3 && v2_ff && (s2_ff.cmd == CMD_LOAD)
                   && (32'(s2_ff.entry_index) < 32'(CUBE_ENTRIES));

   // a cube of at most six levels per channel always fits the table
   assign cube_check_en = (color_mode_ff == MODE_CUBE) && (CUBE_ENTRIES >= CUBE_FULL_ENTRIES)
                       && (levels_ff.red <= MAX_LEVELS) && (levels_ff.green <= MAX_LEVELS)
                       && (levels_ff.blue <= MAX_LEVELS);

   rdpc_cube_ram #(
      .DEPTH  (CUBE_ENTRIES),
      .DATA_W (DATA_W)
   ) u_cube_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (ADDR_W'(s2_ff.entry_index)),
      .wr_data (DATA_W'(s2_ff.entry_pixel)),
      .rd_en   (move3),
      .rd_addr (ADDR_W'(cube_idx)),
      .rd_data (tbl_rd_data)
   );

   always_comb begin
      v1_in = move1 ? req_valid : v1_ff;
      v2_in = move2 ? v1_ff     : v2_ff;
      v3_in = move3 ? v2_ff     : v3_ff;

      s1_in = s1_ff;
      if (move1) begin
         s1_in.cmd         = cmd_type'(req_cmd);
         s1_in.tc          = packed_pixel & OUT_MASK;
         s1_in.entry_index = req_entry_index;
         s1_in.entry_pixel = req_entry_pixel;
      end

      s2_in = move2 ? s1_ff : s2_ff;

      s3_in = s3_ff;
      if (move3) begin
         s3_in.cmd = s2_ff.cmd;
         s3_in.tc  = s2_ff.tc;
         s3_in.hit = cube_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   assign rsp_valid = v3_ff && (s3_ff.cmd == CMD_CONVERT);

   always_comb begin
      if (color_mode_ff == MODE_CUBE) begin
         rsp_pixel_out = s3_ff.hit ? PIX_FIELD_BITS'(tbl_rd_data) : '0;
      end else begin
         rsp_pixel_out = s3_ff.tc;
      end
   end

   `RDPC_ASSERT_IMPLY(a_stall_only_when_full, clock, reset, req_stall, v1_ff && v2_ff && rsp_valid)

   `RDPC_ASSERT_NEXT(a_accept_fills_stage1, clock, reset, req_valid && !req_stall, v1_ff)

   `RDPC_ASSERT_IMPLY(a_cube_index_in_range, clock, reset, rsp_valid && cube_check_en, s3_ff.hit)

endmodule

`default_nettype wire

// ===== dv/tb_rgb_to_display_pixel_converter_unit.sv =====
`default_nettype none

module tb_rgb_to_display_pixel_converter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import rdpc_pkg::*;

   localparam int RANDOM_ITEMS   = 1200;
   localparam int TABLE_DEPTH    = CUBE_ENTRIES_DEF;
   localparam int MAX_WAIT       = 14;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT   = 10;

   // index with no register behind it, writes there must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      cmd_type                   cmd;
      logic [CHAN_BITS-1:0]      red;
      logic [CHAN_BITS-1:0]      green;
      logic [CHAN_BITS-1:0]      blue;
      logic [CHAN_BITS-1:0]      entry;
      logic [PIX_FIELD_BITS-1:0] entry_pixel;
      logic [CSR_INDEX_BITS-1:0] csr_idx;
      logic [MASK_BITS-1:0]      csr_data;
      logic                      fixed;
      logic [PIX_FIELD_BITS-1:0] fixed_pixel;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   cmd_type                   req_cmd = CMD_CONVERT;
   logic [CHAN_BITS-1:0]      req_red_in = '0;
   logic [CHAN_BITS-1:0]      req_green_in = '0;
   logic [CHAN_BITS-1:0]      req_blue_in = '0;
   logic [CHAN_BITS-1:0]      req_entry_index = '0;
   logic [PIX_FIELD_BITS-1:0] req_entry_pixel = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [PIX_FIELD_BITS-1:0] rsp_pixel_out;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [MASK_BITS-1:0]      csr_wdata = '0;

   // shadow of the block's registers and pixel table
   mode_type                  cfg_mode = MODE_TRUE_COLOR;
   logic [MASK_BITS-1:0]      cfg_red_mask = '0;
   logic [MASK_BITS-1:0]      cfg_green_mask = '0;
   logic [MASK_BITS-1:0]      cfg_blue_mask = '0;
   logic [LEVEL_BITS-1:0]     cfg_red_levels = RED_LEVELS_RST;
   logic [LEVEL_BITS-1:0]     cfg_green_levels = GREEN_LEVELS_RST;
   logic [LEVEL_BITS-1:0]     cfg_blue_levels = BLUE_LEVELS_RST;
   logic [PIX_FIELD_BITS-1:0] cube_table [TABLE_DEPTH];
   bit                        table_written [TABLE_DEPTH];

   logic [PIX_FIELD_BITS-1:0] pixel_expect [$];
   stim_row_type              directed_rows [$];

   int                        mismatches = 0;
   int                        idle_cycles = 0;
   int                        n_convert = 0;
   int                        n_cube_convert = 0;
   int                        n_load = 0;
   int                        n_csr = 0;
   int                        n_phases = 0;
   bit                        quiet = 1'b0;
   bit                        progress;
   logic [PIX_FIELD_BITS-1:0] want;

   rgb_to_display_pixel_converter_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_entry_index (req_entry_index),
      .req_entry_pixel (req_entry_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // top set mask bit gets channel msb, only the first eight set bits are used
   function automatic logic [MASK_BITS-1:0] pack_channel(input logic [MASK_BITS-1:0] mask,
                                                         input logic [CHAN_BITS-1:0] value);
      logic [MASK_BITS-1:0] word;
      int                   taken;
      word  = '0;
      taken = 0;
      for (int b = MASK_BITS - 1; b >= 0; b--) begin
         if (mask[b] && taken < CHAN_BITS) begin
            word[b] = value[CHAN_BITS-1-taken];
            taken++;
         end
      end
      return word;
   endfunction

   function automatic int cube_index(input logic [CHAN_BITS-1:0] r,
                                     input logic [CHAN_BITS-1:0] g,
                                     input logic [CHAN_BITS-1:0] b);
      logic [QUANT_PROD_BITS-1:0] pr;
      logic [QUANT_PROD_BITS-1:0] pg;
      logic [QUANT_PROD_BITS-1:0] pb;
      pr = QUANT_PROD_BITS'(r) * QUANT_PROD_BITS'(cfg_red_levels);
      pg = QUANT_PROD_BITS'(g) * QUANT_PROD_BITS'(cfg_green_levels);
      pb = QUANT_PROD_BITS'(b) * QUANT_PROD_BITS'(cfg_blue_levels);
      return (int'(pr[QUANT_PROD_BITS-1:CHAN_BITS]) * int'(cfg_green_levels)
              + int'(pg[QUANT_PROD_BITS-1:CHAN_BITS])) * int'(cfg_blue_levels)
              + int'(pb[QUANT_PROD_BITS-1:CHAN_BITS]);
   endfunction

   function automatic logic [PIX_FIELD_BITS-1:0] predict_pixel(input logic [CHAN_BITS-1:0] r,
                                                               input logic [CHAN_BITS-1:0] g,
                                                               input logic [CHAN_BITS-1:0] b);
      int idx;
      if (cfg_mode == MODE_TRUE_COLOR) begin
         return pack_channel(cfg_red_mask, r) | pack_channel(cfg_green_mask, g)
                | pack_channel(cfg_blue_mask, b);
      end
      idx = cube_index(r, g, b);
      return (idx < TABLE_DEPTH) ? cube_table[idx] : '0;
   endfunction

   function automatic stim_row_type stim_item(input cmd_type cmd,
                                              input logic [CHAN_BITS-1:0] r,
                                              input logic [CHAN_BITS-1:0] g,
                                              input logic [CHAN_BITS-1:0] b,
                                              input logic [CHAN_BITS-1:0] ent,
                                              input logic [PIX_FIELD_BITS-1:0] pix,
                                              input logic fixed,
                                              input logic [PIX_FIELD_BITS-1:0] fixed_pixel);
      stim_row_type row;
      row             = '0;
      row.kind        = ROW_ITEM;
      row.cmd         = cmd;
      row.red         = r;
      row.green       = g;
      row.blue        = b;
      row.entry       = ent;
      row.entry_pixel = pix;
      row.fixed       = fixed;
      row.fixed_pixel = fixed_pixel;
      return row;
   endfunction

   function automatic stim_row_type stim_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                             input logic [MASK_BITS-1:0] data);
      stim_row_type row;
      row          = '0;
      row.kind     = ROW_CSR;
      row.cmd      = CMD_CONVERT;
      row.csr_idx  = idx;
      row.csr_data = data;
      return row;
   endfunction

   function automatic logic [CHAN_BITS-1:0] rand_channel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return CHAN_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [MASK_BITS-1:0] rand_mask();
      int         w;
      int         pos;
      logic [63:0] field;
      case ($urandom_range(0, 7))
         4:       return '1;
         5:       return '0;
         6, 7:    return MASK_BITS'($urandom());
         default: begin
            // contiguous field, the usual display format
            w     = $urandom_range(1, 12);
            pos   = $urandom_range(0, MASK_BITS - w);
            field = ((64'd1 << w) - 64'd1) << pos;
            return field[MASK_BITS-1:0];
         end
      endcase
   endfunction

   // low bits carry the value, upper bits sometimes carry noise
   function automatic logic [MASK_BITS-1:0] pad_word(input logic [LEVEL_BITS-1:0] low,
                                                     input int width);
      logic [MASK_BITS-1:0] w;
      w = ($urandom_range(0, 3) == 0) ? MASK_BITS'($urandom()) : '0;
      for (int i = 0; i < width; i++) w[i] = low[i];
      return w;
   endfunction

   function automatic logic [LEVEL_BITS-1:0] rand_levels();
      if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? 3'd0 : 3'd7;
      return LEVEL_BITS'($urandom_range(1, MAX_LEVELS));
   endfunction

   task automatic note_mismatch(input string what, input logic [PIX_FIELD_BITS-1:0] exp_pix,
                                input logic [PIX_FIELD_BITS-1:0] got_pix);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s: expected %08h, got %08h", $time, what, exp_pix, got_pix);
   endtask

   task automatic send_item(input cmd_type cmd, input logic [CHAN_BITS-1:0] r,
                            input logic [CHAN_BITS-1:0] g, input logic [CHAN_BITS-1:0] b,
                            input logic [CHAN_BITS-1:0] ent,
                            input logic [PIX_FIELD_BITS-1:0] pix, input logic fixed,
                            input logic [PIX_FIELD_BITS-1:0] fixed_pixel);
      int gap;
      if ($urandom_range(0, 99) == 0) quiet = !quiet;
      gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_red_in      <= r;
      req_green_in    <= g;
      req_blue_in     <= b;
      req_entry_index <= ent;
      req_entry_pixel <= pix;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (cmd == CMD_LOAD) begin
         cube_table[ent]    = pix;
         table_written[ent] = 1'b1;
         n_load++;
      end else begin
         pixel_expect.push_back(fixed ? fixed_pixel : predict_pixel(r, g, b));
         n_convert++;
         if (cfg_mode == MODE_CUBE) n_cube_convert++;
      end
   endtask

   // loads give no result, so allow the pipeline to empty past the last one
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pixel_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [MASK_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      n_csr++;
      case (idx)
         CSR_COLOR_MODE:   cfg_mode         = mode_type'(data[0]);
         CSR_RED_MASK:     cfg_red_mask     = data;
         CSR_GREEN_MASK:   cfg_green_mask   = data;
         CSR_BLUE_MASK:    cfg_blue_mask    = data;
         CSR_RED_LEVELS:   cfg_red_levels   = data[LEVEL_BITS-1:0];
         CSR_GREEN_LEVELS: cfg_green_levels = data[LEVEL_BITS-1:0];
         CSR_BLUE_LEVELS:  cfg_blue_levels  = data[LEVEL_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic configure_phase(input int phase);
      logic mode_bit;
      mode_bit = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      wait_until_drained();
      write_register(CSR_COLOR_MODE, pad_word({2'b00, mode_bit}, 1));
      write_register(CSR_RED_MASK, rand_mask());
      write_register(CSR_GREEN_MASK, rand_mask());
      write_register(CSR_BLUE_MASK, rand_mask());
      write_register(CSR_RED_LEVELS, pad_word(rand_levels(), LEVEL_BITS));
      write_register(CSR_GREEN_LEVELS, pad_word(rand_levels(), LEVEL_BITS));
      write_register(CSR_BLUE_LEVELS, pad_word(rand_levels(), LEVEL_BITS));
      csr_valid <= 1'b0;
      n_phases++;
   endtask

   task automatic run_phase(input int count);
      logic [CHAN_BITS-1:0] r;
      logic [CHAN_BITS-1:0] g;
      logic [CHAN_BITS-1:0] b;
      int                   idx;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 39) == 0) wait_until_drained();
         r = rand_channel();
         g = rand_channel();
         b = rand_channel();
         if ($urandom_range(0, 99) < 15) begin
            send_item(CMD_LOAD, r, g, b, CHAN_BITS'($urandom_range(0, 255)),
                      PIX_FIELD_BITS'($urandom()), 1'b0, '0);
         end else begin
            // never read a table entry before it holds a pixel
            if (cfg_mode == MODE_CUBE) begin
               idx = cube_index(r, g, b);
               if (idx < TABLE_DEPTH && !table_written[idx])
                  send_item(CMD_LOAD, rand_channel(), rand_channel(), rand_channel(),
                            CHAN_BITS'(idx), PIX_FIELD_BITS'($urandom()), 1'b0, '0);
            end
            send_item(CMD_CONVERT, r, g, b, CHAN_BITS'($urandom_range(0, 255)),
                      PIX_FIELD_BITS'($urandom()), 1'b0, '0);
         end
      end
   endtask

   // response side back-pressure
   initial begin
      int hold;
      forever begin
         hold = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, MAX_WAIT);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         progress = (req_valid === 1'b1 && req_stall === 1'b0)
                    || (csr_valid === 1'b1 && csr_ready === 1'b1)
                    || (rsp_valid === 1'b1 && rsp_stall === 1'b0);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pixel_expect.size() == 0) begin
               note_mismatch("pixel with no item pending", 'x, rsp_pixel_out);
            end else begin
               want = pixel_expect.pop_front();
               if (rsp_pixel_out !== want) note_mismatch("pixel_out", want, rsp_pixel_out);
            end
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d pixels outstanding",
                     $time, idle_cycles, pixel_expect.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      int  target;
      bit  in_csr;
      // reset defaults: no mask bits, so every pixel is zero
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00, '0, 1'b1, '0));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1, 1'b1, '0));
      // plain 8-8-8 layout
      directed_rows.push_back(stim_csr(CSR_RED_MASK, 32'hFF00_0000));
      directed_rows.push_back(stim_csr(CSR_GREEN_MASK, 32'h00FF_0000));
      directed_rows.push_back(stim_csr(CSR_BLUE_MASK, 32'h0000_FF00));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'hFF, 8'h00, 8'h00, 8'h00, '0, 1'b1,
                                        32'hFF00_0000));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'h12, 8'h34, 8'h56, 8'h00, '0, 1'b1,
                                        32'h1234_5600));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'hFF, 8'hFF, 8'hFF, 8'h00, '0, 1'b1,
                                        32'hFFFF_FF00));
      // full mask: lower 24 bits past the eighth stay clear
      directed_rows.push_back(stim_csr(CSR_RED_MASK, 32'hFFFF_FFFF));
      directed_rows.push_back(stim_csr(CSR_GREEN_MASK, 32'h0000_0000));
      directed_rows.push_back(stim_csr(CSR_BLUE_MASK, 32'h0000_0000));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'hA5, 8'hFF, 8'hFF, 8'h00, '0, 1'b1,
                                        32'hA500_0000));
      // overlapping and sparse masks
      directed_rows.push_back(stim_csr(CSR_RED_MASK, 32'hF0F0_F0F0));
      directed_rows.push_back(stim_csr(CSR_GREEN_MASK, 32'hFFFF_0000));
      directed_rows.push_back(stim_csr(CSR_BLUE_MASK, 32'h0000_FFFF));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'h5A, 8'hC3, 8'h0F, 8'h00, '0, 1'b0, '0));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'hFF, 8'hFF, 8'hFF, 8'h00, '0, 1'b0, '0));
      // color cube with default 6x6x5 levels, corners at entries 0 and 179
      directed_rows.push_back(stim_csr(CSR_COLOR_MODE, 32'h0000_0001));
      directed_rows.push_back(stim_item(CMD_LOAD, 8'h00, 8'h00, 8'h00, 8'd0, 32'hFFFF_FFFF,
                                        1'b0, '0));
      directed_rows.push_back(stim_item(CMD_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'd179, 32'h8000_0001,
                                        1'b0, '0));
      directed_rows.push_back(stim_item(CMD_LOAD, 8'h00, 8'h00, 8'h00, 8'd255, 32'h0000_0000,
                                        1'b0, '0));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'h00, 8'h00, 8'h00, 8'hFF, '1, 1'b1,
                                        32'hFFFF_FFFF));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'hFF, 8'hFF, 8'hFF, 8'h00, '0, 1'b1,
                                        32'h8000_0001));
      // seven levels: the far corner lands past the table and reads as zero
      directed_rows.push_back(stim_csr(CSR_RED_LEVELS, 32'hFFFF_FFFF));
      directed_rows.push_back(stim_csr(CSR_GREEN_LEVELS, 32'h0000_0007));
      directed_rows.push_back(stim_csr(CSR_BLUE_LEVELS, 32'h0000_0007));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'hFF, 8'hFF, 8'hFF, 8'h00, '0, 1'b1, '0));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00, '0, 1'b1,
                                        32'hFFFF_FFFF));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'd200, 8'd40, 8'd120, 8'h00, '0, 1'b0,
                                        '0));
      // zero levels collapse every color onto entry 0
      directed_rows.push_back(stim_csr(CSR_RED_LEVELS, 32'h0000_0000));
      directed_rows.push_back(stim_csr(CSR_GREEN_LEVELS, 32'h0000_0000));
      directed_rows.push_back(stim_csr(CSR_BLUE_LEVELS, 32'h0000_0000));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'hFF, 8'hFF, 8'hFF, 8'h00, '0, 1'b1,
                                        32'hFFFF_FFFF));
      directed_rows.push_back(stim_csr(CSR_UNUSED_INDEX, 32'hFFFF_FFFF));
      directed_rows.push_back(stim_item(CMD_CONVERT, 8'd10, 8'd20, 8'd30, 8'h00, '0, 1'b0, '0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      in_csr = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            if (!in_csr) wait_until_drained();
            write_register(directed_rows[i].csr_idx, directed_rows[i].csr_data);
            in_csr = 1'b1;
         end else begin
            if (in_csr) csr_valid <= 1'b0;
            in_csr = 1'b0;
            send_item(directed_rows[i].cmd, directed_rows[i].red, directed_rows[i].green,
                      directed_rows[i].blue, directed_rows[i].entry,
                      directed_rows[i].entry_pixel, directed_rows[i].fixed,
                      directed_rows[i].fixed_pixel);
         end
      end

      target = n_convert + n_load + RANDOM_ITEMS;
      while (n_convert + n_load < target) begin
         configure_phase(n_phases);
         run_phase($urandom_range(60, 140));
      end

      wait_until_drained();
      $display("ran %0d conversions (%0d through the color cube) and %0d table loads",
               n_convert, n_cube_convert, n_load);
      $display("over %0d register settings, %0d register writes, %0d mismatches",
               n_phases, n_csr, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
